>>> rtl/jet_colormap_entry_top_defines.svh
// assertion macros shared by the jet colormap rtl
`ifndef JET_COLORMAP_ENTRY_TOP_DEFINES_SVH
`define JET_COLORMAP_ENTRY_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define JCE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define JCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/jce_pkg.sv
// shared widths, constants and types of the jet colormap block
package jce_pkg;

   localparam int IDX_W               = 10;
   localparam int SIZE_W              = 11;
   localparam int LEVEL_W             = 16;
   localparam int MAX_ENTRIES_DEFAULT = 1024;
   localparam int SIZE_CAP            = 2047;

   localparam logic [SIZE_W-1:0]  SIZE_RESET = 11'd64;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 16'hFFFF;

   // register enables of the three stages inside a level lane
   typedef struct packed {
      logic en_a;
      logic en_b;
      logic en_c;
   } jce_stage_ctl_type;

endpackage

>>> rtl/jce_ifs.sv
// valid/ready channel interfaces for index requests and color responses
interface jce_req_if;
   import jce_pkg::*;

   logic               valid;
   logic               ready;
   logic [IDX_W-1:0]   entry_index;

   modport source (output valid, output entry_index, input ready);
   modport sink   (input valid, input entry_index, output ready);
endinterface

interface jce_rsp_if;
   import jce_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] red_level;
   logic [LEVEL_W-1:0] green_level;
   logic [LEVEL_W-1:0] blue_level;
   logic               index_valid;

   modport source (output valid, output red_level, output green_level,
                   output blue_level, output index_valid, input ready);
   modport sink   (input valid, input red_level, input green_level,
                   input blue_level, input index_valid, output ready);
endinterface

>>> rtl/jce_cfg.sv
// size register, derived segment length and offset, and reciprocal sequencer
module jce_cfg #(
   parameter int MAX_ENTRIES = jce_pkg::MAX_ENTRIES_DEFAULT,
   parameter int M_W         = 11,
   parameter int N_W         = 10,
   parameter int S           = 27
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [jce_pkg::SIZE_W-1:0] csr_write_data,
   output logic [M_W-1:0]            size_m,
   output logic [N_W-1:0]            seg_n,
   output logic [N_W-1:0]            offset_t,
   output logic [S:0]                recip,
   output logic                      busy
);
   import jce_pkg::*;

   localparam int CW = $clog2(S + 1);

   logic [SIZE_W-1:0] size_src;
   logic [31:0]       m_wide;
   logic [M_W-1:0]    m_in;
   logic [M_W:0]      n_sum;
   logic [N_W-1:0]    n_in;
   logic [N_W:0]      th_sum;
   logic [N_W-1:0]    t_in;

   logic [M_W-1:0]    m_ff;
   logic [N_W-1:0]    n_ff;
   logic [N_W-1:0]    t_ff;

   logic              busy_ff;
   logic [CW-1:0]     cnt_ff;
   logic [N_W-1:0]    rem_ff;
   logic [S:0]        q_ff;
   logic [N_W:0]      shifted;
   logic [N_W:0]      diff;
   logic              qbit;

   // clamp to the supported size, then n = ceil(m/4), t = ceil(n/2) - (m mod 4 == 1)
   always_comb begin
      size_src = reset ? SIZE_RESET : csr_write_data;
      m_wide   = (32'(size_src) > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : 32'(size_src);
      m_in     = m_wide[M_W-1:0];
      n_sum    = {1'b0, m_in} + (M_W+1)'(3);
      n_in     = n_sum[M_W:2];
      th_sum   = {1'b0, n_in} + (N_W+1)'(1);
      t_in     = th_sum[N_W:1] - ((m_in[1:0] == 2'b01) ? N_W'(1) : N_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff <= m_in;
         n_ff <= n_in;
         t_ff <= t_in;
      end else if (csr_write_enable) begin
         m_ff <= m_in;
         n_ff <= n_in;
         t_ff <= t_in;
      end
   end

   // restoring division of 2^S by n, one quotient bit a cycle
   always_comb begin
      shifted = {rem_ff, (cnt_ff == CW'(S))};
      diff    = shifted - {1'b0, n_ff};
      qbit    = (shifted >= {1'b0, n_ff});
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(S);
         rem_ff  <= '0;
         q_ff    <= '0;
      end else if (busy_ff) begin
         rem_ff  <= qbit ? diff[N_W-1:0] : shifted[N_W-1:0];
         q_ff    <= {q_ff[S-1:0], qbit};
         cnt_ff  <= cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign size_m   = m_ff;
   assign seg_n    = n_ff;
   assign offset_t = t_ff;
   assign recip    = q_ff;
   assign busy     = busy_ff;

endmodule

>>> rtl/jce_level.sv
// one color lane: ramp step, scaled product, reciprocal quotient and remainder
module jce_level #(
   parameter int N_W = 10,
   parameter int S   = 27,
   parameter int PW  = 13
) (
   input  logic                          clock,
   input  jce_pkg::jce_stage_ctl_type    ctl,
   input  logic [N_W-1:0]                seg_n,
   input  logic [S:0]                    recip,
   input  logic signed [PW-1:0]          pos,
   output logic [jce_pkg::LEVEL_W-1:0]   level
);
   import jce_pkg::*;

   localparam int PPW = N_W + LEVEL_W;
   localparam int XW  = PPW + S + 1;

   logic signed [PW-1:0] sn;
   logic signed [PW-1:0] len;
   logic signed [PW-1:0] k_full;
   logic [N_W-1:0]       k_in;
   logic [N_W-1:0]       k_ff;

   logic [PPW-1:0]       p_in;
   logic [XW-1:0]        prod_in;
   logic [PPW-1:0]       p_ff;
   logic [XW-1:0]        prod_ff;

   logic [LEVEL_W-1:0]   q0;
   logic [PPW-1:0]       qn;
   logic [PPW-1:0]       rem_full;
   logic [LEVEL_W-1:0]   q0_ff;
   logic [N_W:0]         rem_ff;

   // ramp: rising for pos < n, flat to 2n-2, falling to 3n-2, zero outside
   always_comb begin
      sn  = $signed({{(PW-N_W){1'b0}}, seg_n});
      len = (sn <<< 1) + sn - $signed(PW'(1));
      if (pos < $signed(PW'(0)) || pos >= len) begin
         k_full = '0;
      end else if (pos < sn) begin
         k_full = pos + $signed(PW'(1));
      end else if (pos < len - sn) begin
         k_full = sn;
      end else begin
         k_full = len - pos;
      end
      k_in = k_full[N_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.en_a) begin
         k_ff <= k_in;
      end
   end

   // p = k * 65535, then p * floor(2^S / n)
   always_comb begin
      p_in    = {k_ff, {LEVEL_W{1'b0}}} - PPW'(k_ff);
      prod_in = XW'(p_in) * XW'(recip);
   end

   always_ff @(posedge clock) begin
      if (ctl.en_b) begin
         p_ff    <= p_in;
         prod_ff <= prod_in;
      end
   end

   // estimate is exact or one low; the remainder, below 2n, is compared with n to tell which
   always_comb begin
      q0       = prod_ff[S +: LEVEL_W];
      qn       = PPW'(q0) * PPW'(seg_n);
      rem_full = p_ff - qn;
   end

   always_ff @(posedge clock) begin
      if (ctl.en_c) begin
         q0_ff  <= q0;
         rem_ff <= rem_full[N_W:0];
      end
   end

   assign level = (rem_ff >= {1'b0, seg_n}) ? q0_ff + LEVEL_W'(1) : q0_ff;

endmodule

>>> rtl/jet_colormap_entry_top.sv
// top level of the jet colormap entry generator
//
// usage
//   req carries one entry_index per transaction (valid/ready); rsp returns the
//   red, green and blue levels of that row plus index_valid, which is low (and
//   all levels zero) when the index is at or beyond the colormap size
//   csr_write_enable/csr_write_data load the colormap size m; values above
//   MAX_ENTRIES are treated as MAX_ENTRIES
// throughput and pipeline
//   one transaction per cycle unless a low rsp.ready, a size write or a reciprocal
//   rebuild stalls it; a result is offered on rsp once its request has passed the
//   five register stages (position, ramp step, scaled product, quotient, output)
// reset and size changes
//   reset loads m = 64; after reset and after every size write the reciprocal
//   of n = ceil(m/4) is rebuilt bit by bit, and req.ready stays low while it is
//   being rebuilt
// stalls
//   when rsp.ready is low the stages fill up behind the output register and
//   req.ready drops only once stage one holds a transaction that cannot move
`include "jet_colormap_entry_top_defines.svh"

module jet_colormap_entry_top #(
   parameter int MAX_ENTRIES = jce_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   jce_req_if.sink                    req,
   jce_rsp_if.source                  rsp,
   input  logic                       csr_write_enable,
   input  logic [jce_pkg::SIZE_W-1:0] csr_write_data
);
   import jce_pkg::*;

   // largest usable size, width of m, of n, and of signed ramp positions
   localparam int MCAP  = (MAX_ENTRIES < SIZE_CAP) ? MAX_ENTRIES : SIZE_CAP;
   localparam int M_W   = $clog2(MCAP + 1);
   localparam int N_W   = M_W - 1;
   localparam int S     = N_W + 17;
   localparam int CMP_W = (M_W > IDX_W) ? M_W : IDX_W;
   localparam int PW    = CMP_W + 2;
   localparam int NST   = 5;

   logic [M_W-1:0]       size_m;
   logic [N_W-1:0]       seg_n;
   logic [N_W-1:0]       offset_t;
   logic [S:0]           recip;
   logic                 busy;

   logic [NST-1:0]       en;
   logic [NST-1:0]       valid_ff;
   logic [NST-1:0]       in_range_ff;
   logic                 accept;

   logic signed [PW-1:0] x_s;
   logic signed [PW-1:0] t_s;
   logic signed [PW-1:0] n_s;
   logic signed [PW-1:0] base;
   logic                 in_range_in;
   logic signed [PW-1:0] pos_r_ff;
   logic signed [PW-1:0] pos_g_ff;
   logic signed [PW-1:0] pos_b_ff;

   jce_stage_ctl_type    ctl;
   logic [LEVEL_W-1:0]   red_lvl;
   logic [LEVEL_W-1:0]   green_lvl;
   logic [LEVEL_W-1:0]   blue_lvl;

   logic [LEVEL_W-1:0]   red_ff;
   logic [LEVEL_W-1:0]   green_ff;
   logic [LEVEL_W-1:0]   blue_ff;

   jce_cfg #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .M_W         (M_W),
      .N_W         (N_W),
      .S           (S)
   ) u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .size_m           (size_m),
      .seg_n            (seg_n),
      .offset_t         (offset_t),
      .recip            (recip),
      .busy             (busy)
   );

   // a stage may load when it is empty or the stage after it moves on
   always_comb begin
      en[NST-1] = !valid_ff[NST-1] || rsp.ready;
      for (int i = NST - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   // no new transaction during a size write or while the reciprocal is being rebuilt
   assign req.ready = en[0] && !busy && !csr_write_enable;
   assign accept    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= accept;
         end
         for (int i = 1; i < NST; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // stage one: range check and the three ramp positions
   //   green at x - t, red at x - t - n, blue at x - t + n
   always_comb begin
      x_s         = $signed({{(PW-IDX_W){1'b0}}, req.entry_index});
      t_s         = $signed({{(PW-N_W){1'b0}}, offset_t});
      n_s         = $signed({{(PW-N_W){1'b0}}, seg_n});
      base        = x_s - t_s;
      in_range_in = ({{(CMP_W-IDX_W+1){1'b0}}, req.entry_index}
                     < {{(CMP_W-M_W+1){1'b0}}, size_m});
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pos_r_ff       <= base - n_s;
         pos_g_ff       <= base;
         pos_b_ff       <= base + n_s;
         in_range_ff[0] <= in_range_in;
      end
      for (int i = 1; i < NST; i++) begin
         if (en[i]) begin
            in_range_ff[i] <= in_range_ff[i-1];
         end
      end
   end

   // stages two to four live in the lanes
   assign ctl.en_a = en[1];
   assign ctl.en_b = en[2];
   assign ctl.en_c = en[3];

   jce_level #(.N_W (N_W), .S (S), .PW (PW)) u_red (
      .clock (clock), .ctl (ctl), .seg_n (seg_n), .recip (recip),
      .pos (pos_r_ff), .level (red_lvl)
   );

   jce_level #(.N_W (N_W), .S (S), .PW (PW)) u_green (
      .clock (clock), .ctl (ctl), .seg_n (seg_n), .recip (recip),
      .pos (pos_g_ff), .level (green_lvl)
   );

   jce_level #(.N_W (N_W), .S (S), .PW (PW)) u_blue (
      .clock (clock), .ctl (ctl), .seg_n (seg_n), .recip (recip),
      .pos (pos_b_ff), .level (blue_lvl)
   );

   // output register: out-of-range rows are forced to black
   always_ff @(posedge clock) begin
      if (en[NST-1]) begin
         red_ff   <= in_range_ff[NST-2] ? red_lvl   : '0;
         green_ff <= in_range_ff[NST-2] ? green_lvl : '0;
         blue_ff  <= in_range_ff[NST-2] ? blue_lvl  : '0;
      end
   end

   assign rsp.valid       = valid_ff[NST-1];
   assign rsp.red_level   = red_ff;
   assign rsp.green_level = green_ff;
   assign rsp.blue_level  = blue_ff;
   assign rsp.index_valid = in_range_ff[NST-1];

   `JCE_ASSERT_SAME(a_oor_black, clock, reset,
      rsp.valid && !rsp.index_valid,
      rsp.red_level == '0 && rsp.green_level == '0 && rsp.blue_level == '0,
      "out-of-range row has a nonzero level")
   `JCE_ASSERT_SAME(a_busy_blocks, clock, reset, busy, !req.ready,
      "request taken while reciprocal is rebuilt")
   `JCE_ASSERT_NEXT(a_write_starts, clock, reset, csr_write_enable, busy,
      "size write did not start a reciprocal pass")
   `JCE_ASSERT_SAME(a_out_from_pipe, clock, reset, $rose(rsp.valid),
      $past(valid_ff[NST-2]),
      "response appeared without a transaction in stage four")

endmodule
